### hw/rtl/reply_frame_deframer_assert.svh
// ---------------------------------------------------------------------------
// reply_frame_deframer_assert.svh
// Assertion macros for the reply frame deframer RTL.
// ---------------------------------------------------------------------------
`ifndef REPLY_FRAME_DEFRAMER_ASSERT_SVH
`define REPLY_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication, checked on clk, off while in reset.
`define RFD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk, off while in reset.
`define RFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/rfd_pkg.sv
// ---------------------------------------------------------------------------
// rfd_pkg
// Constants and types for the reply frame deframer.
// ---------------------------------------------------------------------------
package rfd_pkg;

    // Fixed frame bytes
    localparam logic [7:0] HEAD_FIRST  = 8'hAA;
    localparam logic [7:0] HEAD_SECOND = 8'hBB;
    localparam logic [7:0] MARK_BYTE   = 8'h00;
    // Non-data bytes counted in the length byte, among them the id, command and status bytes
    localparam logic [7:0] FIXED_COUNT = 8'd6;

    // Result roles
    localparam logic [2:0] ROLE_ID0    = 3'd0;
    localparam logic [2:0] ROLE_ID1    = 3'd1;
    localparam logic [2:0] ROLE_CMD0   = 3'd2;
    localparam logic [2:0] ROLE_CMD1   = 3'd3;
    localparam logic [2:0] ROLE_STATUS = 3'd4;
    localparam logic [2:0] ROLE_DATA   = 3'd5;
    localparam logic [2:0] ROLE_END    = 3'd6;

    // Error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_FRAME = 2'd1;
    localparam logic [1:0] ERR_STUFF = 2'd2;

    // One parser result, with a flag saying whether the byte produced one
    typedef struct packed {
        logic       emit;
        logic [7:0] byte_value;
        logic [2:0] role;
        logic [7:0] data_index;
        logic       check_ok;
        logic [1:0] error_code;
        logic       last;
    } rfd_result_t;

endpackage

### hw/rtl/rfd_parser.sv
// ---------------------------------------------------------------------------
// rfd_parser
// Frame parsing state machine: consumes one byte per step and yields at
// most one result for it.
// ---------------------------------------------------------------------------
module rfd_parser
    import rfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  rx_byte,
    output rfd_result_t res
);

    typedef enum logic [3:0] {
        PH_HEAD0  = 4'd0,
        PH_HEAD1  = 4'd1,
        PH_LEN    = 4'd2,
        PH_MARK   = 4'd3,
        PH_ID0    = 4'd4,
        PH_ID1    = 4'd5,
        PH_CMD0   = 4'd6,
        PH_CMD1   = 4'd7,
        PH_STATUS = 4'd8,
        PH_DATA   = 4'd9,
        PH_VER    = 4'd10
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] remaining_reg, remaining_next;
    logic [7:0] position_reg, position_next;
    logic [7:0] xor_reg, xor_next;
    logic       stuff_reg, stuff_next;
    logic [7:0] remaining_dec;

    assign remaining_dec = remaining_reg - 8'd1;

    // Next state and result for the current byte
    always_comb
    begin
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        position_next  = position_reg;
        xor_next       = xor_reg;
        stuff_next     = stuff_reg;
        res            = '0;
        res.byte_value = rx_byte;
        res.role       = ROLE_END;

        unique case (phase_reg)
            PH_HEAD0:
            begin
                if (rx_byte != HEAD_FIRST)
                begin
                    res.emit       = 1'b1;
                    res.error_code = ERR_FRAME;
                    res.last       = 1'b1;
                    stuff_next     = 1'b0;
                end
                else
                begin
                    phase_next = PH_HEAD1;
                end
            end
            PH_HEAD1:
            begin
                if (rx_byte != HEAD_SECOND)
                begin
                    res.emit       = 1'b1;
                    res.error_code = ERR_FRAME;
                    res.last       = 1'b1;
                    phase_next     = PH_HEAD0;
                    stuff_next     = 1'b0;
                end
                else
                begin
                    phase_next = PH_LEN;
                end
            end
            PH_LEN:
            begin
                remaining_next = (rx_byte > FIXED_COUNT) ? (rx_byte - FIXED_COUNT) : 8'd0;
                position_next  = 8'd0;
                xor_next       = 8'd0;
                stuff_next     = 1'b0;
                phase_next     = PH_MARK;
            end
            PH_MARK:
            begin
                if (rx_byte != MARK_BYTE)
                begin
                    res.emit       = 1'b1;
                    res.error_code = ERR_FRAME;
                    res.last       = 1'b1;
                    phase_next     = PH_HEAD0;
                    stuff_next     = 1'b0;
                end
                else
                begin
                    phase_next = PH_ID0;
                end
            end
            PH_ID0, PH_ID1, PH_CMD0, PH_CMD1, PH_STATUS:
            begin
                res.emit = 1'b1;
                res.role = 3'(4'(phase_reg) - 4'(PH_ID0));
                xor_next = xor_reg ^ rx_byte;
                if (phase_reg == PH_STATUS)
                    phase_next = (remaining_reg == 8'd0) ? PH_VER : PH_DATA;
                else
                    phase_next = phase_t'(4'(phase_reg) + 4'd1);
            end
            PH_DATA:
            begin
                if (stuff_reg)
                begin
                    // byte after a data 0xAA must be the stuffed zero
                    if (rx_byte != MARK_BYTE)
                    begin
                        res.emit       = 1'b1;
                        res.error_code = ERR_STUFF;
                        res.last       = 1'b1;
                        phase_next     = PH_HEAD0;
                        stuff_next     = 1'b0;
                    end
                    else
                    begin
                        stuff_next = 1'b0;
                        if (remaining_reg == 8'd0)
                            phase_next = PH_VER;
                    end
                end
                else
                begin
                    res.emit       = 1'b1;
                    res.role       = ROLE_DATA;
                    res.data_index = position_reg;
                    xor_next       = xor_reg ^ rx_byte;
                    position_next  = position_reg + 8'd1;
                    remaining_next = remaining_dec;
                    if (rx_byte == HEAD_FIRST)
                        stuff_next = 1'b1;
                    else if (remaining_dec == 8'd0)
                        phase_next = PH_VER;
                end
            end
            PH_VER:
            begin
                res.emit     = 1'b1;
                res.check_ok = (rx_byte == xor_reg);
                res.last     = 1'b1;
                phase_next   = PH_HEAD0;
            end
            default:
            begin
                res.emit       = 1'b1;
                res.error_code = ERR_FRAME;
                res.last       = 1'b1;
                phase_next     = PH_HEAD0;
                stuff_next     = 1'b0;
            end
        endcase
    end

    // Parser state, updated once per consumed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEAD0;
            remaining_reg <= 8'd0;
            position_reg  <= 8'd0;
            xor_reg       <= 8'd0;
            stuff_reg     <= 1'b0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            position_reg  <= position_next;
            xor_reg       <= xor_next;
            stuff_reg     <= stuff_next;
        end
    end

endmodule

### hw/rtl/reply_frame_deframer.sv
// ---------------------------------------------------------------------------
// reply_frame_deframer
// Parses byte-stuffed reply frames with an XOR check from a byte stream.
// ---------------------------------------------------------------------------
// Takes one received byte per word on the slave side and reports every id,
// command, status and data byte of a reply frame on the master side, with
// its role and data index; the verification byte ends the frame with
// check_ok and tlast. A bad head, a bad marker or a missing stuffed zero
// gives one error word (tlast set) and the parser hunts for 0xAA again.
// Head, length, marker and stuffed zero bytes give no word. Throughput is
// one byte per clock while the master side takes its words. A byte accepted
// sits in the input register, goes through the parser, and its word shows
// on the master side from the result register. While a result waits for
// tready the input register takes one more byte; after that s_tready stays
// low until the result is taken.
module reply_frame_deframer
    import rfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] byte_value, [15:8] data_index
    output logic [5:0]  m_tuser,   // [2:0] role, [3] check_ok, [5:4] error_code
    output logic        m_tlast
);

`include "reply_frame_deframer_assert.svh"

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg;
    rfd_result_t out_reg;
    rfd_result_t res;
    logic        advance;
    logic        stalled;
    logic        word_err;
    logic        word_end;
    logic        word_data;

    // Parser consumes the held byte when the result register is free or its word is taken
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_byte_reg <= s_tdata;
    end

    rfd_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .res     (res)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= res.emit;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.emit)
            out_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.data_index, out_reg.byte_value};
    assign m_tuser  = {out_reg.error_code, out_reg.check_ok, out_reg.role};
    assign m_tlast  = out_reg.last;

    // Result word decode for the checks
    assign stalled   = in_valid_reg && !advance;
    assign word_err  = (m_tuser[5:4] != ERR_NONE);
    assign word_end  = (m_tuser[2:0] == ROLE_END);
    assign word_data = (m_tuser[2:0] == ROLE_DATA);

    // Checks
    `RFD_ASSERT_IMPL(a_err_ends, m_tvalid && word_err, m_tlast && word_end, "error word not final")
    `RFD_ASSERT_IMPL(a_ok_at_end, m_tvalid && m_tuser[3], word_end && !word_err, "check_ok off end")
    `RFD_ASSERT_IMPL(a_idx_data, m_tvalid && !word_data, m_tdata[15:8] == 8'd0, "index off data")
    `RFD_ASSERT_NEXT(a_hold_byte, stalled, in_valid_reg && $stable(in_byte_reg), "held byte lost")

endmodule
